// ===== rtl/cmyg_pkg.sv =====
// shared types, constants and the mosaic phase table of the cmyg demosaic block
// no dependencies; imported by every module of the block
`default_nettype none

package cmyg_pkg;

  localparam int unsigned CMYG_MAX_WIDTH = 4096;
  localparam int unsigned PIX_W          = 16;
  localparam int unsigned CFG_WIDTH_W    = 13;
  localparam int unsigned Q_DEPTH        = 4;
  localparam int unsigned Q_PTR_W        = $clog2(Q_DEPTH);

  // register map
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_X_PHASE     = 2'd1;
  localparam logic [1:0] REG_Y_PHASE     = 2'd2;

  localparam logic [CFG_WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd4096;
  localparam logic                   X_PHASE_RST     = 1'b1;
  localparam logic [1:0]             Y_PHASE_RST     = 2'd2;

  // floor(s/3) = (s * DIV3_MUL) >> DIV3_SHIFT, exact for s < 2**19
  localparam int unsigned SUM3_W     = PIX_W + 2;
  localparam logic [SUM3_W-1:0] DIV3_MUL = 18'd174763;
  localparam int unsigned DIV3_SHIFT = 19;

  // window positions
  localparam logic [1:0] WIN_CUR   = 2'd0;
  localparam logic [1:0] WIN_LEFT  = 2'd1;
  localparam logic [1:0] WIN_ABOVE = 2'd2;
  localparam logic [1:0] WIN_UL    = 2'd3;

  typedef struct packed {
    logic [1:0] yel;
    logic [1:0] cya;
    logic [1:0] mag;
  } pick_t;

  // picked colour samples travelling from front to back
  typedef struct packed {
    logic [PIX_W-1:0] yel;
    logic [PIX_W-1:0] cya;
    logic [PIX_W-1:0] mag;
    logic             last;
  } cmy_t;

  function automatic pick_t phase_pick(input logic [2:0] mode);
    pick_t p;
    unique case (mode)
      3'd0:    p = '{yel: WIN_LEFT,  cya: WIN_CUR,   mag: WIN_ABOVE};
      3'd1:    p = '{yel: WIN_CUR,   cya: WIN_LEFT,  mag: WIN_UL};
      3'd2:    p = '{yel: WIN_UL,    cya: WIN_ABOVE, mag: WIN_LEFT};
      3'd3:    p = '{yel: WIN_ABOVE, cya: WIN_UL,    mag: WIN_CUR};
      3'd4:    p = '{yel: WIN_LEFT,  cya: WIN_CUR,   mag: WIN_UL};
      3'd5:    p = '{yel: WIN_CUR,   cya: WIN_LEFT,  mag: WIN_ABOVE};
      3'd6:    p = '{yel: WIN_UL,    cya: WIN_ABOVE, mag: WIN_CUR};
      default: p = '{yel: WIN_ABOVE, cya: WIN_UL,    mag: WIN_LEFT};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cmyg_mosaic_to_rgb.sv =====
// top level of the cmyg mosaic to rgb converter: register port, front, queue, back
// depends on cmyg_pkg, cmyg_front, cmyg_fifo and cmyg_back
`default_nettype none

// Takes one raw 16-bit CMYG mosaic pixel per clock when not full, in raster order, and
// gives red, green, blue and luminance from the 2x2 window ending at each pixel outside
// the first row and first column; row_end marks the last result of a row. One pixel is
// accepted every cycle while results are taken: the line store is a single memory read
// and written once per beat, and the divide by three is a registered reciprocal multiply.
// The line store holds no valid state: rows must not be made wider in mid-frame. The user
// must write registers over the APB port at 0x0 (image_width), 0x4 (x_phase) and 0x8
// (y_phase) only while the block is idle; the block does not enforce this.
module cmyg_mosaic_to_rgb import cmyg_pkg::*; #(
  parameter int unsigned MAX_WIDTH = CMYG_MAX_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [PIX_W-1:0]   raw_pixel_i,
  input  wire logic               frame_start_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic      [PIX_W-1:0]   red_o,
  output logic      [PIX_W-1:0]   green_o,
  output logic      [PIX_W-1:0]   blue_o,
  output logic      [PIX_W-1:0]   luminance_o,
  output logic                    row_end_o
);

  logic [CFG_WIDTH_W-1:0] image_width_q;
  logic                   x_phase_q;
  logic [1:0]             y_phase_q;
  logic                   cfg_wr;
  logic [1:0]             reg_idx;
  logic                   q_push, q_full, q_pop, q_empty;
  cmy_t                   q_wr_data, q_rd_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RST;
      x_phase_q     <= X_PHASE_RST;
      y_phase_q     <= Y_PHASE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH: image_width_q <= pwdata[CFG_WIDTH_W-1:0];
        REG_X_PHASE:     x_phase_q     <= pwdata[0];
        REG_Y_PHASE:     y_phase_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH: prdata = 32'(image_width_q);
      REG_X_PHASE:     prdata = 32'(x_phase_q);
      REG_Y_PHASE:     prdata = 32'(y_phase_q);
      default:         prdata = '0;
    endcase
  end

  cmyg_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .raw_pixel_i   (raw_pixel_i),
    .frame_start_i (frame_start_i),
    .image_width_i (image_width_q),
    .x_phase_i     (x_phase_q),
    .y_phase_i     (y_phase_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wr_data)
  );

  cmyg_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_push),
    .wr_data_i (q_wr_data),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_rd_data),
    .empty_o   (q_empty)
  );

  cmyg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rd_data),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .luminance_o (luminance_o),
    .row_end_o   (row_end_o)
  );

endmodule

`default_nettype wire

// ===== rtl/cmyg_front.sv =====
// front end: raster position tracking, line store, 2x2 window and colour picking
// depends on cmyg_pkg
`default_nettype none

module cmyg_front import cmyg_pkg::*; #(
  parameter int unsigned MAX_WIDTH = CMYG_MAX_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  output logic                        full_o,
  input  wire logic [PIX_W-1:0]       raw_pixel_i,
  input  wire logic                   frame_start_i,
  input  wire logic [CFG_WIDTH_W-1:0] image_width_i,
  input  wire logic                   x_phase_i,
  input  wire logic [1:0]             y_phase_i,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output cmy_t                        q_data_o
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned MWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW  = (MWW > CFG_WIDTH_W) ? MWW : CFG_WIDTH_W;

  logic [AW-1:0]    col_q, col_d, x;
  logic [1:0]       row_q, row_d, row_eff;
  logic             past_q, past_d, past_eff;
  logic             s1_valid_q, s1_valid_d;
  logic             accept, s1_move, emit, last;
  logic [WW-1:0]    width_cfg, width_eff;
  logic [1:0]       yy;
  logic             xx;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] above_q, left_q;
  logic [PIX_W-1:0] s1_raw_q, s1_left_q, s1_ul_q;
  logic [2:0]       s1_mode_q;
  logic             s1_last_q;
  pick_t            sel;

  function automatic logic [PIX_W-1:0] win_sel(input logic [1:0] pos,
                                                input logic [PIX_W-1:0] cur,
                                                input logic [PIX_W-1:0] lft,
                                                input logic [PIX_W-1:0] abv,
                                                input logic [PIX_W-1:0] ul);
    logic [PIX_W-1:0] v;
    unique case (pos)
      WIN_CUR:   v = cur;
      WIN_LEFT:  v = lft;
      WIN_ABOVE: v = abv;
      default:   v = ul;
    endcase
    return v;
  endfunction

  assign s1_move = s1_valid_q && !q_full_i;
  assign full_o  = s1_valid_q && q_full_i;
  assign accept  = push_i && !full_o;

  // width below 2 acts as 2, above the store size as the store size
  assign width_cfg = WW'(image_width_i);
  always_comb begin
    if (width_cfg < WW'(2)) begin
      width_eff = WW'(2);
    end else if (width_cfg > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_cfg;
    end
  end

  assign x        = frame_start_i ? '0 : col_q;
  assign row_eff  = frame_start_i ? 2'd0 : row_q;
  assign past_eff = frame_start_i ? 1'b0 : past_q;
  assign last     = (WW'(x) + WW'(1)) >= width_eff;
  assign emit     = (x != '0) && past_eff;
  assign yy       = y_phase_i + row_eff;
  assign xx       = x_phase_i ^ x[0];

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    past_d     = past_q;
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = emit;
      if (last) begin
        col_d  = '0;
        row_d  = row_eff + 2'd1;
        past_d = 1'b1;
      end else begin
        col_d  = x + AW'(1);
        row_d  = row_eff;
        past_d = past_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= 2'd0;
      past_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      past_q     <= past_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // line store read before write; above_q keeps the last read for the upper-left tap
  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q     <= line_mem[x];
      line_mem[x] <= raw_pixel_i;
      s1_ul_q     <= above_q;
      s1_left_q   <= left_q;
      left_q      <= raw_pixel_i;
      s1_raw_q    <= raw_pixel_i;
      s1_mode_q   <= {yy, xx};
      s1_last_q   <= last;
    end
  end

  assign sel           = phase_pick(s1_mode_q);
  assign q_push_o      = s1_move;
  assign q_data_o.yel  = win_sel(sel.yel, s1_raw_q, s1_left_q, above_q, s1_ul_q);
  assign q_data_o.cya  = win_sel(sel.cya, s1_raw_q, s1_left_q, above_q, s1_ul_q);
  assign q_data_o.mag  = win_sel(sel.mag, s1_raw_q, s1_left_q, above_q, s1_ul_q);
  assign q_data_o.last = s1_last_q;

endmodule

`default_nettype wire

// ===== rtl/cmyg_fifo.sv =====
// short queue of picked colour samples between front and back
// depends on cmyg_pkg
`default_nettype none

module cmyg_fifo import cmyg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_en_i,
  input  wire cmy_t wr_data_i,
  output logic      full_o,
  input  wire logic rd_en_i,
  output cmy_t      rd_data_o,
  output logic      empty_o
);

  cmy_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q;

  assign full_o    = count_q == (Q_PTR_W + 1)'(Q_DEPTH);
  assign empty_o   = count_q == '0;
  assign rd_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + (Q_PTR_W + 1)'(1);
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - (Q_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmyg_back.sv =====
// back end: colour sums, divide by three via reciprocal multiply, result register
// depends on cmyg_pkg
`default_nettype none

module cmyg_back import cmyg_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_empty_i,
  input  wire cmy_t         q_data_i,
  output logic              q_pop_o,
  input  wire logic         pop,
  output logic              empty,
  output logic [PIX_W-1:0]  red_o,
  output logic [PIX_W-1:0]  green_o,
  output logic [PIX_W-1:0]  blue_o,
  output logic [PIX_W-1:0]  luminance_o,
  output logic              row_end_o
);

  localparam int unsigned PROD_W = 2 * SUM3_W;

  logic                a_valid_q, b_valid_q, o_valid_q;
  logic                a_ready, b_ready, o_ready;
  logic [PIX_W:0]      my_sum, cy_sum, mc_sum;
  logic [SUM3_W-1:0]   cmy_sum;
  logic [PIX_W-1:0]    a_red_q, a_green_q, a_blue_q, b_red_q, b_green_q, b_blue_q;
  logic [SUM3_W-1:0]   a_sum3_q;
  logic                a_last_q, b_last_q;
  logic [PROD_W-1:0]   b_prod_q;

  assign o_ready = !o_valid_q || pop;
  assign b_ready = !b_valid_q || o_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign q_pop_o = !q_empty_i && a_ready;
  assign empty   = !o_valid_q;

  assign my_sum  = {1'b0, q_data_i.mag} + {1'b0, q_data_i.yel};
  assign cy_sum  = {1'b0, q_data_i.cya} + {1'b0, q_data_i.yel};
  assign mc_sum  = {1'b0, q_data_i.mag} + {1'b0, q_data_i.cya};
  assign cmy_sum = SUM3_W'(mc_sum) + SUM3_W'(q_data_i.yel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= !q_empty_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (o_ready) begin
        o_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_red_q   <= my_sum[PIX_W:1];
      a_green_q <= cy_sum[PIX_W:1];
      a_blue_q  <= mc_sum[PIX_W:1];
      a_sum3_q  <= cmy_sum;
      a_last_q  <= q_data_i.last;
    end
    if (b_ready && a_valid_q) begin
      b_red_q   <= a_red_q;
      b_green_q <= a_green_q;
      b_blue_q  <= a_blue_q;
      b_prod_q  <= a_sum3_q * DIV3_MUL;
      b_last_q  <= a_last_q;
    end
    if (o_ready && b_valid_q) begin
      red_o       <= b_red_q;
      green_o     <= b_green_q;
      blue_o      <= b_blue_q;
      luminance_o <= b_prod_q[DIV3_SHIFT +: PIX_W];
      row_end_o   <= b_last_q;
    end
  end

endmodule

`default_nettype wire
